[hdl/tis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and constants of the synthetic IPv4/TCP header generator.
// ----------------------------------------------------------------------------
package tis_pkg;

  localparam logic [15:0] IP_VER_IHL_TOS  = 16'h4500;
  localparam logic [15:0] IP_DONT_FRAG    = 16'h4000;
  localparam logic [7:0]  IP_PROTO_TCP    = 8'd6;
  localparam logic [15:0] HDR_TOTAL_BYTES = 16'd40;
  localparam logic [15:0] TCP_WINDOW      = 16'd32768;
  localparam logic [3:0]  TCP_DOFF        = 4'd5;
  localparam logic [7:0]  FL_FIN          = 8'h01;
  localparam logic [7:0]  FL_SYN          = 8'h02;
  localparam logic [7:0]  FL_ACK          = 8'h10;
  localparam logic [7:0]  HOP_RESET       = 8'd64;
  localparam logic [3:0]  WORD_FIRST      = 4'd0;
  localparam logic [3:0]  WORD_LAST       = 4'd9;

  typedef enum logic [2:0] {
    CFG_CLIENT_ADDR = 3'd0,
    CFG_SERVER_ADDR = 3'd1,
    CFG_CLIENT_PORT = 3'd2,
    CFG_SERVER_PORT = 3'd3,
    CFG_HOP_LIMIT   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        from_server;
    logic        flag_syn;
    logic        flag_fin;
    logic        flag_ack;
    logic [15:0] payload_length;
  } in_t;

  typedef struct packed {
    logic [31:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] server_addr;
    logic [15:0] client_port;
    logic [15:0] server_port;
    logic [7:0]  hop_limit;
  } cfg_t;

  // everything needed to serialise one segment's header
  typedef struct packed {
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [7:0]  hop_limit;
    logic [15:0] csum;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [31:0] ackno;
    logic [7:0]  flags;
  } seg_t;

endpackage

[hdl/tis_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_state
// Per-direction sequence, acknowledge and identification counters, and the
// header fields (with IPv4 checksum) of the segment being taken.
// ----------------------------------------------------------------------------
module tis_state (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  tis_pkg::in_t  item_i,
  input  tis_pkg::cfg_t cfg_i,
  output tis_pkg::seg_t seg_o
);
  import tis_pkg::*;

  logic [31:0] seq_tc_q, seq_tc_d, seq_ts_q, seq_ts_d;
  logic [31:0] acked_tc_q, acked_tc_d, acked_ts_q, acked_ts_d;
  logic [15:0] ident_tc_q, ident_tc_d, ident_ts_q, ident_ts_d;

  logic [31:0] my_seq, other_seq, my_acked, seq_next, seq_inc;
  logic [15:0] my_ident;
  logic        syn_or_fin;
  logic [7:0]  flags;
  logic [15:0] total_len;
  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  always_comb begin
    if (item_i.from_server) begin
      my_seq    = seq_tc_q;
      other_seq = seq_ts_q;
      my_acked  = acked_tc_q;
      my_ident  = ident_tc_q;
    end else begin
      my_seq    = seq_ts_q;
      other_seq = seq_tc_q;
      my_acked  = acked_ts_q;
      my_ident  = ident_ts_q;
    end
  end

  assign syn_or_fin = item_i.flag_syn | item_i.flag_fin;
  assign seq_inc    = syn_or_fin ? 32'd1 : {16'd0, item_i.payload_length};
  assign seq_next   = my_seq + seq_inc;

  always_comb begin
    flags = 8'd0;
    if (item_i.flag_syn) flags = flags | FL_SYN;
    if (item_i.flag_fin) flags = flags | FL_FIN;
    if (item_i.flag_ack || !syn_or_fin) flags = flags | FL_ACK;
    // opposite side moved on: acknowledge it unless opening
    if ((other_seq != my_acked) && !item_i.flag_syn) flags = flags | FL_ACK;
  end

  assign total_len = HDR_TOTAL_BYTES + item_i.payload_length;

  assign seg_o.src_addr = item_i.from_server ? cfg_i.server_addr : cfg_i.client_addr;
  assign seg_o.dst_addr = item_i.from_server ? cfg_i.client_addr : cfg_i.server_addr;
  assign seg_o.src_port = item_i.from_server ? cfg_i.server_port : cfg_i.client_port;
  assign seg_o.dst_port = item_i.from_server ? cfg_i.client_port : cfg_i.server_port;

  // one's complement sum over the ten header halfwords, end-around carry
  always_comb begin
    sum = 20'(IP_VER_IHL_TOS) + 20'(total_len) + 20'(my_ident) + 20'(IP_DONT_FRAG)
        + 20'({cfg_i.hop_limit, IP_PROTO_TCP})
        + 20'(seg_o.src_addr[31:16]) + 20'(seg_o.src_addr[15:0])
        + 20'(seg_o.dst_addr[31:16]) + 20'(seg_o.dst_addr[15:0]);
    fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  assign seg_o.total_len = total_len;
  assign seg_o.ident     = my_ident;
  assign seg_o.hop_limit = cfg_i.hop_limit;
  assign seg_o.csum      = ~fold2;
  assign seg_o.seq       = my_seq;
  assign seg_o.ackno     = other_seq;
  assign seg_o.flags     = flags;

  always_comb begin
    seq_tc_d   = seq_tc_q;
    seq_ts_d   = seq_ts_q;
    acked_tc_d = acked_tc_q;
    acked_ts_d = acked_ts_q;
    ident_tc_d = ident_tc_q;
    ident_ts_d = ident_ts_q;
    if (take_i) begin
      if (item_i.from_server) begin
        seq_tc_d   = seq_next;
        acked_tc_d = other_seq;
        ident_tc_d = my_ident + 16'd1;
      end else begin
        seq_ts_d   = seq_next;
        acked_ts_d = other_seq;
        ident_ts_d = my_ident + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_tc_q   <= '0;
      seq_ts_q   <= '0;
      acked_tc_q <= '0;
      acked_ts_q <= '0;
      ident_tc_q <= '0;
      ident_ts_q <= '0;
    end else begin
      seq_tc_q   <= seq_tc_d;
      seq_ts_q   <= seq_ts_d;
      acked_tc_q <= acked_tc_d;
      acked_ts_q <= acked_ts_d;
      ident_tc_q <= ident_tc_d;
      ident_ts_q <= ident_ts_d;
    end
  end

endmodule

[hdl/tis_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_serial
// Holds one segment's header fields and sends them out as ten 32-bit words
// through a registered output stage.
// ----------------------------------------------------------------------------
module tis_serial (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seg_load_i,
  input  tis_pkg::seg_t seg_i,
  output logic          seg_ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tis_pkg::out_t out_data_o
);
  import tis_pkg::*;

  logic          seg_valid_q, seg_valid_d;
  tis_pkg::seg_t seg_q;
  logic [3:0]    cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  tis_pkg::out_t out_q;
  logic          out_free, word_move, seg_done;
  logic [31:0]   word;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign word_move   = seg_valid_q && out_free;
  assign seg_done    = word_move && (cnt_q == WORD_LAST);
  assign seg_ready_o = !seg_valid_q || seg_done;

  always_comb begin
    case (cnt_q)
      4'd0:    word = {IP_VER_IHL_TOS, seg_q.total_len};
      4'd1:    word = {seg_q.ident, IP_DONT_FRAG};
      4'd2:    word = {seg_q.hop_limit, IP_PROTO_TCP, seg_q.csum};
      4'd3:    word = seg_q.src_addr;
      4'd4:    word = seg_q.dst_addr;
      4'd5:    word = {seg_q.src_port, seg_q.dst_port};
      4'd6:    word = seg_q.seq;
      4'd7:    word = seg_q.ackno;
      4'd8:    word = {TCP_DOFF, 4'd0, seg_q.flags, TCP_WINDOW};
      default: word = 32'd0;
    endcase
  end

  always_comb begin
    seg_valid_d = seg_valid_q;
    cnt_d       = cnt_q;
    if (word_move) cnt_d = seg_done ? WORD_FIRST : cnt_q + 4'd1;
    if (seg_done) seg_valid_d = 1'b0;
    if (seg_load_i) seg_valid_d = 1'b1;
    out_valid_d = out_free ? seg_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
      cnt_q       <= WORD_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      seg_valid_q <= seg_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_load_i) seg_q <= seg_i;
    if (word_move) begin
      out_q.header_word <= word;
      out_q.word_index  <= cnt_q;
      out_q.last_word   <= (cnt_q == WORD_LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/tcp_ipv4_header_synth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_ipv4_header_synth
// Synthetic IPv4 + TCP header generator, ten 32-bit words per segment.
// ----------------------------------------------------------------------------
// usage:
//   in channel: one word per TCP segment (direction, syn/fin/ack, payload
//   length), valid/stall handshake, taken when valid is high and stall low
//   out channel: ten header words per segment, word_index 0..9, last_word on
//   the tenth, same valid/stall handshake
//   config port: write enable, register index and data; write only when idle
//   path: the first header word passes the input register, segment buffer
//   and output register; the other nine follow one a cycle while not stalled
//   pacing: the 32-bit output port carries each segment as ten words; the
//   next segment is taken while the current one is still being sent
//   reset: counters and sequence state go to zero, addresses and ports to
//   zero, hop limit to 64; no clearing pass
//   receiver stall: the output word holds, the segment buffer and input
//   register fill up and then stall is raised towards the sender
// ----------------------------------------------------------------------------
module tcp_ipv4_header_synth (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tis_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tis_pkg::out_t     out_data_o
);
  import tis_pkg::*;

  tis_pkg::cfg_t cfg_q, cfg_d;
  logic          in_valid_q, in_valid_d;
  tis_pkg::in_t  in_q;
  logic          take, seg_ready, in_load;
  tis_pkg::seg_t seg;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLIENT_ADDR: cfg_d.client_addr = cfg_data_i;
        CFG_SERVER_ADDR: cfg_d.server_addr = cfg_data_i;
        CFG_CLIENT_PORT: cfg_d.client_port = cfg_data_i[15:0];
        CFG_SERVER_PORT: cfg_d.server_port = cfg_data_i[15:0];
        CFG_HOP_LIMIT:   cfg_d.hop_limit   = cfg_data_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  assign take       = in_valid_q && seg_ready;
  assign in_stall_o = in_valid_q && !seg_ready;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take) in_valid_d = 1'b0;
    if (in_load) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.client_addr <= '0;
      cfg_q.server_addr <= '0;
      cfg_q.client_port <= '0;
      cfg_q.server_port <= '0;
      cfg_q.hop_limit   <= HOP_RESET;
      in_valid_q        <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) in_q <= in_data_i;
  end

  tis_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .seg_o  (seg)
  );

  tis_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_load_i  (take),
    .seg_i       (seg),
    .seg_ready_o (seg_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // last word flag and index agree
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == WORD_LAST)))
    else $error("last_word does not match word_index");

  // words of a segment come back to back once one has been taken
  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_word) |=>
      (out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 4'd1)))
    else $error("header word sequence broken");

  // a new segment always starts at word zero
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_word) |=>
      (!out_valid_o || (out_data_o.word_index == WORD_FIRST)))
    else $error("segment did not start at word zero");

  // stall only raised with a word waiting in the input register
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && !seg_ready))
    else $error("input stalled without a waiting word");

endmodule

[dv/tb_tcp_ipv4_header_synth.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_ipv4_header_synth
// Self-checking bench for the synthetic IPv4/TCP header generator. A table of
// hand-picked segments runs first, then random traffic in four phases with
// different idle/stall rates and address/port/TTL settings. Every accepted
// segment is turned into ten expected header words by a local model of the
// sequence, ack and identification state; output words are checked in order.
// ----------------------------------------------------------------------------
module tb_tcp_ipv4_header_synth;
  import tis_pkg::*;

  localparam int          N_DIRECTED     = 16;
  localparam int          N_PER_PHASE    = 100;
  localparam int          N_PHASES       = 4;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [2:0]  CFG_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  CFG_SPARE_LAST  = 3'd7;

  localparam int SEND_IDLE  [N_PHASES] = '{0, 66, 0, 14};
  localparam int RECV_STALL [N_PHASES] = '{0, 0, 66, 14};

  // a word position whose value is known by inspection
  typedef struct packed {
    logic        on;
    logic [3:0]  idx;
    logic [31:0] word;
  } pin_t;

  typedef struct packed {
    logic        srv;
    logic        syn;
    logic        fin;
    logic        ack;
    logic [15:0] plen;
    logic        pin_on;
    logic [3:0]  pin_idx;
    logic [31:0] pin_word;
  } row_t;

  //                 srv  syn  fin  ack  plen      pin  idx   word
  localparam row_t SEG_TAB [N_DIRECTED] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1, 4'd2, 32'h4006_3AD1},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b1, 4'd0, 32'h4500_0027},
    '{1'b1, 1'b0, 1'b0, 1'b0, 16'hFFD7, 1'b1, 4'd0, 32'h4500_FFFF},
    '{1'b1, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1, 4'd9, 32'h0000_0000},
    '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 4'd0, 32'h0},
    '{1'b1, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b0, 4'd0, 32'h0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'h0001, 1'b0, 4'd0, 32'h0},
    '{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 4'd0, 32'h0},
    '{1'b1, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, 4'd0, 32'h0},
    '{1'b0, 1'b1, 1'b1, 1'b1, 16'hAAAA, 1'b0, 4'd0, 32'h0},
    '{1'b1, 1'b1, 1'b1, 1'b0, 16'h5555, 1'b0, 4'd0, 32'h0},
    '{1'b0, 1'b0, 1'b0, 1'b0, 16'h5555, 1'b0, 4'd0, 32'h0},
    '{1'b1, 1'b0, 1'b0, 1'b0, 16'hAAAA, 1'b0, 4'd0, 32'h0},
    '{1'b0, 1'b0, 1'b0, 1'b1, 16'h8000, 1'b0, 4'd0, 32'h0},
    '{1'b1, 1'b1, 1'b0, 1'b0, 16'h7FFF, 1'b0, 4'd0, 32'h0},
    '{1'b0, 1'b0, 1'b1, 1'b1, 16'h1234, 1'b0, 4'd0, 32'h0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = 3'd0;
  logic [31:0] cfg_data_i  = 32'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;

  pin_t        seg_pin     = '0;
  logic        hold_off    = 1'b0;
  logic        press_go    = 1'b0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          n_err          = 0;

  // index 1 = toward client (sent by the server), index 0 = toward server
  logic [31:0] next_seq [2] = '{32'd0, 32'd0};
  logic [31:0] acked    [2] = '{32'd0, 32'd0};
  logic [15:0] ip_id    [2] = '{16'd0, 16'd0};
  cfg_t        cfg_shadow   = '{32'd0, 32'd0, 16'd0, 16'd0, HOP_RESET};

  out_t        hdr_q [$];
  out_t        exp_w;

  tcp_ipv4_header_synth dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_header(in_t s, pin_t pin);
    logic [31:0] w [10];
    logic [31:0] sum;
    logic [31:0] peer_seq;
    logic [31:0] seq_sent;
    logic [7:0]  fl;
    out_t        o;
    logic        d;
    d        = s.from_server;
    peer_seq = next_seq[~d];
    seq_sent = next_seq[d];

    fl = 8'h00;
    if (s.flag_syn) fl |= FL_SYN;
    if (s.flag_fin) fl |= FL_FIN;
    if (s.flag_ack || (!s.flag_syn && !s.flag_fin)) fl |= FL_ACK;

    next_seq[d] = seq_sent + ((s.flag_syn || s.flag_fin) ? 32'd1 : {16'd0, s.payload_length});
    // peer has moved since we last acked it
    if (peer_seq != acked[d]) begin
      acked[d] = peer_seq;
      if (!s.flag_syn) fl |= FL_ACK;
    end

    w[0] = {IP_VER_IHL_TOS, HDR_TOTAL_BYTES + s.payload_length};
    w[1] = {ip_id[d], IP_DONT_FRAG};
    ip_id[d] = ip_id[d] + 16'd1;
    w[2] = {cfg_shadow.hop_limit, IP_PROTO_TCP, 16'h0000};
    w[3] = d ? cfg_shadow.server_addr : cfg_shadow.client_addr;
    w[4] = d ? cfg_shadow.client_addr : cfg_shadow.server_addr;

    // ones' complement sum over the IPv4 header, carries folded back in
    sum = 32'd0;
    for (int k = 0; k < 5; k++) sum = sum + 32'(w[k][31:16]) + 32'(w[k][15:0]);
    while (sum[31:16] != 16'd0) sum = 32'(sum[31:16]) + 32'(sum[15:0]);
    w[2][15:0] = ~sum[15:0];

    w[5] = d ? {cfg_shadow.server_port, cfg_shadow.client_port}
             : {cfg_shadow.client_port, cfg_shadow.server_port};
    w[6] = seq_sent;
    w[7] = peer_seq;
    w[8] = {TCP_DOFF, 4'h0, fl, TCP_WINDOW};
    w[9] = 32'd0;
    if (pin.on) w[pin.idx] = pin.word;

    for (int k = int'(WORD_FIRST); k <= int'(WORD_LAST); k++) begin
      o.header_word = w[k];
      o.word_index  = k[3:0];
      o.last_word   = (o.word_index == WORD_LAST);
      hdr_q.push_back(o);
    end
  endfunction

  // expectations are made at the acceptance edge, then output words checked
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) predict_header(in_data_i, seg_pin);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hdr_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("unexpected word %h idx %0d last %0b", out_data_o.header_word,
                   out_data_o.word_index, out_data_o.last_word);
      end else begin
        exp_w = hdr_q.pop_front();
        if (out_data_o.header_word !== exp_w.header_word ||
            out_data_o.word_index !== exp_w.word_index ||
            out_data_o.last_word !== exp_w.last_word) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("word mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                     exp_w.header_word, exp_w.word_index, exp_w.last_word,
                     out_data_o.header_word, out_data_o.word_index,
                     out_data_o.last_word);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off so the block fills up and pushes back
  initial begin
    wait (press_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_segment(in_t s, pin_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    seg_pin    <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_CLIENT_ADDR: cfg_shadow.client_addr = val;
      CFG_SERVER_ADDR: cfg_shadow.server_addr = val;
      CFG_CLIENT_PORT: cfg_shadow.client_port = val[15:0];
      CFG_SERVER_PORT: cfg_shadow.server_port = val[15:0];
      CFG_HOP_LIMIT:   cfg_shadow.hop_limit   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_CLIENT_ADDR, c.client_addr);
    write_reg(CFG_SERVER_ADDR, c.server_addr);
    // unused upper bits carry noise, the block must drop them
    write_reg(CFG_CLIENT_PORT, {junk[31:16], c.client_port});
    write_reg(CFG_SERVER_PORT, {junk[15:0], c.server_port});
    write_reg(CFG_HOP_LIMIT, {junk[23:0], c.hop_limit});
    for (int i = int'(CFG_SPARE_FIRST); i <= int'(CFG_SPARE_LAST); i++)
      write_reg(i[2:0], $urandom);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (hdr_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_t random_segment();
    in_t s;
    s.from_server = 1'($urandom_range(1));
    s.flag_syn    = ($urandom_range(7) == 0);
    s.flag_fin    = ($urandom_range(7) == 0);
    s.flag_ack    = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1:    s.payload_length = 16'($urandom);
      2:       s.payload_length = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: s.payload_length = 16'($urandom_range(1460));
    endcase
    return s;
  endfunction

  initial begin
    cfg_t c;
    in_t  s;
    pin_t p;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-picked segments at reset settings
    for (int i = 0; i < N_DIRECTED; i++) begin
      s = {SEG_TAB[i].srv, SEG_TAB[i].syn, SEG_TAB[i].fin, SEG_TAB[i].ack, SEG_TAB[i].plen};
      p = {SEG_TAB[i].pin_on, SEG_TAB[i].pin_idx, SEG_TAB[i].pin_word};
      send_segment(s, p);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF};
        1: c = '{32'd0, 32'd0, 16'd0, 16'd0, 8'd0};
        default: begin
          c.client_addr = $urandom;
          c.server_addr = $urandom;
          c.client_port = 16'($urandom_range(65535));
          c.server_port = 16'($urandom_range(65535));
          c.hop_limit   = 8'($urandom_range(255));
        end
      endcase
      set_config(c);
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      if (ph == 0) press_go = 1'b1;
      for (int n = 0; n < N_PER_PHASE; n++) send_segment(random_segment(), '0);
      in_valid_i <= 1'b0;
      wait_drained();
    end

    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
